@@ hdl/qoi_rgb_pixel_encoder_assert.svh @@
// ----------------------------------------------------------------------------
// qoi_rgb_pixel_encoder_assert.svh
// assertion macros for the checker file of the encoder
// ----------------------------------------------------------------------------
`ifndef QOI_RGB_PIXEL_ENCODER_ASSERT_SVH
`define QOI_RGB_PIXEL_ENCODER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define QOI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define QOI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/qoi_pkg.sv @@
// ----------------------------------------------------------------------------
// qoi_pkg
// types, opcodes and the index hash of the QOI pixel encoder
// ----------------------------------------------------------------------------
package qoi_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int MAX_BYTES     = 5;
  localparam int COUNT_W       = $clog2(MAX_BYTES + 1);
  localparam int RUN_W         = 6;

  localparam logic [7:0] OP_INDEX = 8'h00;
  localparam logic [7:0] OP_DIFF  = 8'h40;
  localparam logic [7:0] OP_LUMA  = 8'h80;
  localparam logic [7:0] OP_RUN   = 8'hC0;
  localparam logic [7:0] OP_RGB   = 8'hFE;

  localparam logic [RUN_W-1:0] RUN_LIMIT = RUN_W'(62);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic   valid;
    pixel_t pixel;
  } seen_entry_t;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [COUNT_W-1:0]        count;
    logic [RUN_W-1:0]          run_next;
  } chunk_t;

  // index position: (r*3 + g*5 + b*7 + 255*11) mod 64
  function automatic logic [SLOT_W-1:0] slot_of(pixel_t p);
    logic [12:0] sum;
    sum = 13'(p.red) * 13'd3 + 13'(p.green) * 13'd5 + 13'(p.blue) * 13'd7 + 13'd2805;
    return sum[SLOT_W-1:0];
  endfunction

endpackage

@@ hdl/qoi_if.sv @@
// ----------------------------------------------------------------------------
// qoi_if
// valid/ready channels for pixels in and chunk bytes out
// ----------------------------------------------------------------------------
interface qoi_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       final_pixel;

  modport source (output valid, red, green, blue, final_pixel, input ready);
  modport sink (input valid, red, green, blue, final_pixel, output ready);
endinterface

interface qoi_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       burst_end;

  modport source (output valid, code_byte, burst_end, input ready);
  modport sink (input valid, code_byte, burst_end, output ready);
endinterface

@@ hdl/qoi_rgb_pixel_encoder.sv @@
// ----------------------------------------------------------------------------
// qoi_rgb_pixel_encoder
// QOI chunk encoder for a stream of RGB pixels (alpha 255)
//
// pixel: one RGB pixel per transaction; final_pixel marks the image's last
//   pixel and flushes a pending run. code: one chunk byte per transaction,
//   burst_end set on the last byte a pixel produces. Header and end marker
//   are not produced.
// A pixel is registered on acceptance together with its index table read,
//   then encoded into a byte burst held in the output shift register, which
//   presents the first byte once the burst is loaded.
// One pixel per cycle while chunks are zero or one byte long and code is
//   ready; longer chunks hold the output register until their last byte
//   is taken, stalling the pixel side, as the byte output is single-port.
// Reset clears previous pixel (black), run count and all index valid bits;
//   the encoder accepts pixels in the first cycle after reset.
// A stall on code holds the current byte stable and backs up into the
//   pixel channel once the stage in front of the output register is full.
// ----------------------------------------------------------------------------
module qoi_rgb_pixel_encoder import qoi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  qoi_pixel_if.sink pixel,
  qoi_code_if.source code
);

  logic                      v1;
  pixel_t                    pix1;
  logic                      last1;
  logic [SLOT_W-1:0]         slot1;
  pixel_t                    prev;
  logic [RUN_W-1:0]          run_count;
  logic [MAX_BYTES-1:0][7:0] burst;
  logic [COUNT_W-1:0]        cnt;

  pixel_t            pix_in;
  logic [SLOT_W-1:0] slot_in;
  logic              accept_in;
  logic              take;
  logic              burst_free;
  logic              fire;
  seen_entry_t       entry;
  chunk_t            chunk;

  assign pix_in     = '{red: pixel.red, green: pixel.green, blue: pixel.blue};
  assign slot_in    = slot_of(pix_in);
  assign take       = code.valid && code.ready;
  assign burst_free = (cnt == '0) || ((cnt == COUNT_W'(1)) && code.ready);
  assign fire       = v1 && burst_free;
  assign pixel.ready = !v1 || burst_free;
  assign accept_in  = pixel.valid && pixel.ready;

  qoi_seen_table u_seen (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept_in),
    .rd_slot  (slot_in),
    .wr_en    (fire),
    .wr_slot  (slot1),
    .wr_pixel (pix1),
    .entry    (entry)
  );

  qoi_chunk_enc u_enc (
    .pixel       (pix1),
    .final_pixel (last1),
    .slot        (slot1),
    .entry       (entry),
    .prev        (prev),
    .run_count   (run_count),
    .chunk       (chunk)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      prev      <= '0;
      run_count <= '0;
      cnt       <= '0;
    end else begin
      if (accept_in) begin
        v1 <= 1'b1;
      end else if (fire) begin
        v1 <= 1'b0;
      end
      if (fire) begin
        prev      <= pix1;
        run_count <= chunk.run_next;
      end
      if (fire && (chunk.count != '0)) begin
        cnt <= chunk.count;
      end else if (take) begin
        cnt <= cnt - COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      pix1  <= pix_in;
      last1 <= pixel.final_pixel;
      slot1 <= slot_in;
    end
    if (fire && (chunk.count != '0)) begin
      burst <= chunk.bytes;
    end else if (take) begin
      burst <= {8'h00, burst[MAX_BYTES-1:1]};
    end
  end

  assign code.valid     = (cnt != '0);
  assign code.code_byte = burst[0];
  assign code.burst_end = (cnt == COUNT_W'(1));

endmodule

@@ hdl/qoi_seen_table.sv @@
// ----------------------------------------------------------------------------
// qoi_seen_table
// 64-entry index of seen pixels with valid bits and registered read
// ----------------------------------------------------------------------------
module qoi_seen_table import qoi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_slot,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_slot,
  input  pixel_t            wr_pixel,
  output seen_entry_t       entry
);

  pixel_t                   mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_bits;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot] <= wr_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (wr_en) begin
      valid_bits[wr_slot] <= 1'b1;
    end
  end

  // write in the same cycle to the same slot is forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_slot == rd_slot)) begin
        entry.pixel <= wr_pixel;
        entry.valid <= 1'b1;
      end else begin
        entry.pixel <= mem[rd_slot];
        entry.valid <= valid_bits[rd_slot];
      end
    end
  end

endmodule

@@ hdl/qoi_chunk_enc.sv @@
// ----------------------------------------------------------------------------
// qoi_chunk_enc
// chooses run, diff, index, luma or rgb chunk for one pixel
// ----------------------------------------------------------------------------
module qoi_chunk_enc import qoi_pkg::*; (
  input  pixel_t            pixel,
  input  logic              final_pixel,
  input  logic [SLOT_W-1:0] slot,
  input  seen_entry_t       entry,
  input  pixel_t            prev,
  input  logic [RUN_W-1:0]  run_count,
  output chunk_t            chunk
);

  logic              same;
  logic              hit;
  logic [7:0]        dr, dg, db;
  logic [8:0]        drg, dbg;
  logic [7:0]        dr2, dg2, db2, dg32;
  logic [8:0]        drg8, dbg8;
  logic              is_diff, is_luma;
  logic [RUN_W-1:0]  run_inc;
  logic [3:0][7:0]   c;
  logic [COUNT_W-1:0] cn;

  assign same = (pixel == prev);
  assign hit  = entry.valid && (entry.pixel == pixel);

  assign dr  = pixel.red - prev.red;
  assign dg  = pixel.green - prev.green;
  assign db  = pixel.blue - prev.blue;
  assign drg = {dr[7], dr} - {dg[7], dg};
  assign dbg = {db[7], db} - {dg[7], dg};

  assign dr2  = dr + 8'd2;
  assign dg2  = dg + 8'd2;
  assign db2  = db + 8'd2;
  assign dg32 = dg + 8'd32;
  assign drg8 = drg + 9'd8;
  assign dbg8 = dbg + 9'd8;

  assign is_diff = ($signed(dr) >= -8'sd2) && ($signed(dr) <= 8'sd1) &&
                   ($signed(dg) >= -8'sd2) && ($signed(dg) <= 8'sd1) &&
                   ($signed(db) >= -8'sd2) && ($signed(db) <= 8'sd1);
  assign is_luma = ($signed(dg) >= -8'sd32) && ($signed(dg) <= 8'sd31) &&
                   ($signed(drg) >= -9'sd8) && ($signed(drg) <= 9'sd7) &&
                   ($signed(dbg) >= -9'sd8) && ($signed(dbg) <= 9'sd7);

  assign run_inc = run_count + RUN_W'(1);

  // the pixel's own chunk
  always_comb begin
    c  = '0;
    cn = COUNT_W'(1);
    if (is_diff) begin
      c[0] = OP_DIFF | {2'b00, dr2[1:0], dg2[1:0], db2[1:0]};
    end else if (hit) begin
      c[0] = OP_INDEX | {2'b00, slot};
    end else if (is_luma) begin
      c[0] = OP_LUMA | {2'b00, dg32[5:0]};
      c[1] = {drg8[3:0], dbg8[3:0]};
      cn   = COUNT_W'(2);
    end else begin
      c[0] = OP_RGB;
      c[1] = pixel.red;
      c[2] = pixel.green;
      c[3] = pixel.blue;
      cn   = COUNT_W'(4);
    end
  end

  always_comb begin
    chunk = '0;
    if (same) begin
      if ((run_inc >= RUN_LIMIT) || final_pixel) begin
        chunk.bytes[0] = OP_RUN | {2'b00, run_count};
        chunk.count    = COUNT_W'(1);
        chunk.run_next = '0;
      end else begin
        chunk.count    = '0;
        chunk.run_next = run_inc;
      end
    end else begin
      chunk.run_next = '0;
      if (run_count != '0) begin
        chunk.bytes[0]   = OP_RUN | {2'b00, run_count - RUN_W'(1)};
        chunk.bytes[4:1] = c;
        chunk.count      = cn + COUNT_W'(1);
      end else begin
        chunk.bytes[3:0] = c;
        chunk.count      = cn;
      end
    end
  end

endmodule

@@ hdl/qoi_checker.sv @@
// ----------------------------------------------------------------------------
// qoi_checker
// port-level checks of the QOI pixel encoder, bound to the top level
// ----------------------------------------------------------------------------
`include "qoi_rgb_pixel_encoder_assert.svh"

module qoi_checker (
  input logic       clk,
  input logic       rst,
  input logic       pixel_ready,
  input logic       code_valid,
  input logic       code_ready,
  input logic [7:0] code_byte,
  input logic       burst_end
);

  // nothing pending right after reset
  `QOI_ASSERT_IMP(a_reset_idle, $past(rst), !code_valid && pixel_ready, "not idle after reset")

  // a burst continues without a gap until its last byte
  `QOI_ASSERT_NXT(a_burst_cont, code_valid && code_ready && !burst_end, code_valid, "gap in burst")

  // stalled byte holds
  `QOI_ASSERT_NXT(a_stall_hold, code_valid && !code_ready, code_valid && $stable(code_byte) && $stable(burst_end), "stalled transaction changed")

endmodule

bind qoi_rgb_pixel_encoder qoi_checker u_qoi_checker (
  .clk         (clk),
  .rst         (rst),
  .pixel_ready (pixel.ready),
  .code_valid  (code.valid),
  .code_ready  (code.ready),
  .code_byte   (code.code_byte),
  .burst_end   (code.burst_end)
);

@@ tb/qoi_rgb_pixel_encoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qoi_rgb_pixel_encoder_tb
// self-checking bench for the QOI RGB pixel encoder
//
// Pixels go in over the pixel channel, and a behavioral encoder in the bench
// predicts the chunk bytes for each accepted pixel. Each received byte and
// its burst_end flag are checked against the oldest predicted byte. Directed
// tests cover runs, final-pixel flush, diff and luma bounds, index hits, RGB
// literals and the run cap. A long receiver hold-off fills the pipeline and
// must stall the pixel side. Random streams then mix runs, small steps, index
// revisits, luma steps and literals, most with random gaps on both sides.
// ----------------------------------------------------------------------------
module qoi_rgb_pixel_encoder_tb;
  import qoi_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int MAX_PRINTED    = 20;

  typedef struct {
    logic [7:0] code_byte;
    logic       burst_end;
  } code_beat_t;

  logic clk;
  logic rst;

  qoi_pixel_if pixel_bus ();
  qoi_code_if  code_bus ();

  qoi_rgb_pixel_encoder u_dut (
    .clk   (clk),
    .rst   (rst),
    .pixel (pixel_bus),
    .code  (code_bus)
  );

  // encoder state as seen by the bench
  pixel_t     prev_px;
  int         run_len;
  pixel_t     seen_px [TABLE_ENTRIES];
  bit         seen_ok [TABLE_ENTRIES];
  code_beat_t code_expect[$];

  int error_count;
  int quiet_cycles;
  bit gaps_on;
  int ready_stall;
  int code_hold_cycles;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom_range(1, 2);
    if (roll < 95) return $urandom_range(3, 6);
    return $urandom_range(12, 30);
  endfunction

  function automatic pixel_t mk_px(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pixel_t px;
    px.red   = r;
    px.green = g;
    px.blue  = b;
    return px;
  endfunction

  function automatic int table_slot(pixel_t px);
    int sum;
    sum = int'(px.red) * 3 + int'(px.green) * 5 + int'(px.blue) * 7 + 255 * 11;
    return sum % TABLE_ENTRIES;
  endfunction

  function automatic void encode_pixel(pixel_t px, bit fin);
    logic [7:0] out[$];
    logic [7:0] d8r, d8g, d8b;
    int         dr, dg, db, drg, dbg, slot;
    code_beat_t beat;
    d8r  = px.red - prev_px.red;
    d8g  = px.green - prev_px.green;
    d8b  = px.blue - prev_px.blue;
    dr   = $signed(d8r);
    dg   = $signed(d8g);
    db   = $signed(d8b);
    drg  = dr - dg;
    dbg  = db - dg;
    slot = table_slot(px);
    if (px == prev_px) begin
      run_len++;
      if (run_len >= RUN_LIMIT || fin) begin
        out.push_back(OP_RUN | 8'(run_len - 1));
        run_len = 0;
      end
    end else begin
      if (run_len > 0) begin
        out.push_back(OP_RUN | 8'(run_len - 1));
        run_len = 0;
      end
      if (dr >= -2 && dr <= 1 && dg >= -2 && dg <= 1 && db >= -2 && db <= 1) begin
        out.push_back(OP_DIFF | 8'((dr + 2) * 16 + (dg + 2) * 4 + (db + 2)));
      end else if (seen_ok[slot] && seen_px[slot] == px) begin
        out.push_back(OP_INDEX | 8'(slot));
      end else if (dg >= -32 && dg <= 31 && drg >= -8 && drg <= 7 &&
                   dbg >= -8 && dbg <= 7) begin
        out.push_back(OP_LUMA | 8'(dg + 32));
        out.push_back(8'((drg + 8) * 16 + (dbg + 8)));
      end else begin
        out.push_back(OP_RGB);
        out.push_back(px.red);
        out.push_back(px.green);
        out.push_back(px.blue);
      end
    end
    seen_px[slot] = px;
    seen_ok[slot] = 1'b1;
    prev_px       = px;
    foreach (out[i]) begin
      beat.code_byte = out[i];
      beat.burst_end = (i == out.size() - 1);
      code_expect.push_back(beat);
    end
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("mismatch at %0t: %s got %02h want %02h", $time, what, got, want);
  endtask

  // called in a clock-edge step; returns in the step of acceptance
  task automatic send_pixel(pixel_t px, bit fin);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 3) == 0) gap = pick_gap();
    if (gap > 0) begin
      pixel_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_bus.valid       <= 1'b1;
    pixel_bus.red         <= px.red;
    pixel_bus.green       <= px.green;
    pixel_bus.blue        <= px.blue;
    pixel_bus.final_pixel <= fin;
    do @(posedge clk); while (!pixel_bus.ready);
    encode_pixel(px, fin);
  endtask

  always @(posedge clk) begin
    code_beat_t want;
    if (!rst && code_bus.valid && code_bus.ready) begin
      if (code_expect.size() == 0) begin
        report_mismatch("unexpected code_byte", code_bus.code_byte, 8'h00);
      end else begin
        want = code_expect.pop_front();
        if (code_bus.code_byte !== want.code_byte)
          report_mismatch("code_byte", code_bus.code_byte, want.code_byte);
        if (code_bus.burst_end !== want.burst_end)
          report_mismatch("burst_end", 8'(code_bus.burst_end), 8'(want.burst_end));
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      code_bus.ready <= 1'b0;
    end else if (code_hold_cycles > 0) begin
      code_bus.ready <= 1'b0;
      code_hold_cycles--;
    end else if (ready_stall > 0) begin
      code_bus.ready <= 1'b0;
      ready_stall--;
    end else begin
      code_bus.ready <= 1'b1;
      if (gaps_on && $urandom_range(0, 3) == 0) ready_stall = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst || (pixel_bus.valid && pixel_bus.ready) || (code_bus.valid && code_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("** qoi_rgb_pixel_encoder: FAILED **");
        $finish;
      end
    end
  end

  task automatic test_runs_and_final();
    gaps_on = 1'b1;
    send_pixel(mk_px(8'd0, 8'd0, 8'd0), 1'b0);
    send_pixel(mk_px(8'd0, 8'd0, 8'd0), 1'b0);
    send_pixel(mk_px(8'd0, 8'd0, 8'd0), 1'b1);
    send_pixel(mk_px(8'd0, 8'd0, 8'd0), 1'b1);
    send_pixel(mk_px(8'd0, 8'd0, 8'd0), 1'b0);
    // run broken by a wrapping diff
    send_pixel(mk_px(8'd255, 8'd255, 8'd255), 1'b0);
  endtask

  task automatic test_diff_bounds();
    gaps_on = 1'b0;
    send_pixel(mk_px(8'd0, 8'd253, 8'd0), 1'b0);
    send_pixel(mk_px(8'd254, 8'd254, 8'd254), 1'b0);
    send_pixel(mk_px(8'd255, 8'd252, 8'd0), 1'b0);
  endtask

  task automatic test_index_luma_literal();
    gaps_on = 1'b1;
    send_pixel(mk_px(8'd10, 8'd200, 8'd30), 1'b0);
    send_pixel(mk_px(8'd0, 8'd253, 8'd0), 1'b0);
    send_pixel(mk_px(8'd216, 8'd221, 8'd231), 1'b0);
    send_pixel(mk_px(8'd254, 8'd252, 8'd254), 1'b0);
    send_pixel(mk_px(8'd30, 8'd28, 8'd30), 1'b0);
    send_pixel(mk_px(8'd10, 8'd200, 8'd30), 1'b0);
    send_pixel(mk_px(8'hAA, 8'h55, 8'hAA), 1'b0);
    send_pixel(mk_px(8'h55, 8'hAA, 8'h55), 1'b1);
    send_pixel(mk_px(8'hFF, 8'h00, 8'hFF), 1'b0);
  endtask

  task automatic test_run_cap();
    pixel_t px;
    gaps_on = 1'b0;
    px = mk_px(8'd7, 8'd7, 8'd7);
    send_pixel(px, 1'b0);
    repeat (63) send_pixel(px, 1'b0);
    send_pixel(mk_px(8'd8, 8'd7, 8'd7), 1'b0);
    px = mk_px(8'd8, 8'd7, 8'd7);
    repeat (60) send_pixel(px, 1'b0);
    send_pixel(px, 1'b1);
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    code_hold_cycles = 80;
    repeat (24) send_pixel(mk_px(8'($urandom), 8'($urandom), 8'($urandom)), 1'b0);
  endtask

  task automatic test_random_stream(int n_items, bit with_gaps);
    pixel_t px;
    pixel_t recent[$];
    int     left, kind, reps, dg;
    gaps_on = with_gaps;
    left    = n_items;
    while (left > 0) begin
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
        reps = ($urandom_range(0, 9) == 0) ? $urandom_range(55, 70) : $urandom_range(1, 6);
        repeat (reps) send_pixel(prev_px, $urandom_range(0, 24) == 0);
        left -= reps;
      end else begin
        if (kind < 40) begin
          px.red   = prev_px.red + 8'($urandom_range(0, 3)) - 8'd2;
          px.green = prev_px.green + 8'($urandom_range(0, 3)) - 8'd2;
          px.blue  = prev_px.blue + 8'($urandom_range(0, 3)) - 8'd2;
        end else if (kind < 55 && recent.size() > 0) begin
          px = recent[$urandom_range(0, recent.size() - 1)];
        end else if (kind < 75) begin
          dg       = int'($urandom_range(0, 63)) - 32;
          px.green = prev_px.green + 8'(dg);
          px.red   = prev_px.red + 8'(dg + int'($urandom_range(0, 15)) - 8);
          px.blue  = prev_px.blue + 8'(dg + int'($urandom_range(0, 15)) - 8);
        end else begin
          px = mk_px(8'($urandom), 8'($urandom), 8'($urandom));
        end
        send_pixel(px, $urandom_range(0, 24) == 0);
        recent.push_back(px);
        if (recent.size() > 16) void'(recent.pop_front());
        left--;
      end
    end
  endtask

  initial begin
    rst                   <= 1'b1;
    pixel_bus.valid       <= 1'b0;
    pixel_bus.red         <= 8'd0;
    pixel_bus.green       <= 8'd0;
    pixel_bus.blue        <= 8'd0;
    pixel_bus.final_pixel <= 1'b0;
    prev_px          = '0;
    run_len          = 0;
    error_count      = 0;
    quiet_cycles     = 0;
    gaps_on          = 1'b0;
    ready_stall      = 0;
    code_hold_cycles = 0;
    foreach (seen_ok[i]) begin
      seen_ok[i] = 1'b0;
      seen_px[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_runs_and_final();
    test_diff_bounds();
    test_index_luma_literal();
    test_run_cap();
    test_backpressure();
    test_random_stream(40, 1'b1);
    test_random_stream(20, 1'b0);
    test_random_stream(25, 1'b1);

    pixel_bus.valid <= 1'b0;
    while (code_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("** qoi_rgb_pixel_encoder: PASSED **");
    end else begin
      $display("** qoi_rgb_pixel_encoder: FAILED **");
    end
    $finish;
  end

endmodule
